>>> src/bitmap_nearest_free_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap allocator
// Shared property forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_NEAREST_FREE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_NEAREST_FREE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BNFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BNFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bnfa_pkg.sv
// ----------------------------------------------------------------------------
// bnfa_pkg
// Types, sizes and helpers shared by the bitmap allocator modules.
// ----------------------------------------------------------------------------
package bnfa_pkg;

	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = 2048;
	localparam int WORD_IDX_W = $clog2(WORD_BITS);
	localparam int ADDR_W     = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W  = 16;
	localparam int LIMIT_W    = 17;

	localparam logic [LIMIT_W-1:0] TOTAL_BITS = LIMIT_W'(MAP_WORDS * WORD_BITS);
	localparam logic [ADDR_W-1:0]  LAST_WORD  = ADDR_W'(MAP_WORDS - 1);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED  = 2'd0,
		ST_NONE_FREE  = 2'd1,
		ST_FREED      = 2'd2,
		ST_FREE_ERROR = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	typedef struct packed {
		status_t               status;
		logic [BIT_IDX_W-1:0]  bit_number;
	} result_t;

	function automatic logic [WORD_IDX_W-1:0] lowest_set(input word_t w);
		logic [WORD_IDX_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = WORD_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> src/bnfa_ram.sv
// ----------------------------------------------------------------------------
// bnfa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bnfa_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[raddr];
	end

	assign rdata = rd_data_q;

endmodule

>>> src/bnfa_ctrl.sv
// ----------------------------------------------------------------------------
// bnfa_ctrl
// Sequencer: clears the map after reset, scans words for allocate, and
// does read-modify-write of the map RAM.
// ----------------------------------------------------------------------------
`include "bitmap_nearest_free_allocator_core_macros.svh"

module bnfa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bnfa_pkg::LIMIT_W-1:0]  limit,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [bnfa_pkg::BIT_IDX_W-1:0] bit_index,
	input  logic                          slot_free,
	output logic                          res_valid,
	output bnfa_pkg::result_t             res
);
	import bnfa_pkg::*;

	state_t                 state_q, state_d;
	req_t                   req_q;
	logic [BIT_IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]      cur_word_q;
	logic [ADDR_W-1:0]      cnt_q;

	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	word_t                  mem_wdata;
	logic [ADDR_W-1:0]      mem_raddr;
	word_t                  rdata;

	word_t                  freebits;
	logic [WORD_IDX_W-1:0]  lo;
	logic [BIT_IDX_W-1:0]   cand;
	logic                   found;
	word_t                  bitmask;
	logic                   idx_in_range;
	logic                   bit_used;
	logic                   finish;
	logic                   accept;
	logic                   in_range_in;
	logic [BIT_IDX_W-1:0]   origin;
	logic [ADDR_W-1:0]      next_word;

	bnfa_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_comb begin
		freebits     = ~rdata;
		lo           = lowest_set(freebits);
		cand         = {cur_word_q, lo};
		found        = (|freebits) && ({1'b0, cand} < limit);
		bitmask      = word_t'(1) << idx_q[WORD_IDX_W-1:0];
		idx_in_range = {1'b0, idx_q} < limit;
		bit_used     = |(rdata & bitmask);
		next_word    = (cur_word_q == LAST_WORD) ? '0 : cur_word_q + 1'b1;
		in_range_in  = {1'b0, bit_index} < limit;
		origin       = in_range_in ? bit_index : '0;
		if (req_q == REQ_ALLOC) begin
			finish = found || (cnt_q == LAST_WORD);
		end else begin
			finish = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (finish && slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		res_valid      = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = cur_word_q;
		mem_wdata      = rdata;
		mem_raddr      = cur_word_q;
		res.status     = ST_NONE_FREE;
		res.bit_number = idx_q;
		if (req_q == REQ_ALLOC) begin
			if (found) begin
				res.status     = ST_ALLOCATED;
				res.bit_number = cand;
			end
		end else begin
			res.status = (idx_in_range && bit_used) ? ST_FREED : ST_FREE_ERROR;
		end
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_CHECK: begin
				res_valid = finish && slot_free;
				if (!finish) begin
					mem_raddr = next_word;
				end
				if (req_q == REQ_ALLOC) begin
					mem_we    = res_valid && found;
					mem_wdata = rdata | (word_t'(1) << lo);
				end else begin
					mem_we    = res_valid && idx_in_range && bit_used;
					mem_wdata = rdata & ~bitmask;
				end
			end
			default: begin
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cnt_q      <= '0;
			cur_word_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (accept) begin
				cnt_q <= '0;
				if (req_type == REQ_ALLOC) begin
					cur_word_q <= origin[WORD_IDX_W +: ADDR_W];
				end else begin
					cur_word_q <= bit_index[WORD_IDX_W +: ADDR_W];
				end
			end else if (state_q == S_CHECK && !finish) begin
				cnt_q      <= cnt_q + 1'b1;
				cur_word_q <= next_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			idx_q <= bit_index;
		end
	end

	`BNFA_ASSERT_NEXT(a_accept_reads, accept, state_q == S_READ, "accept did not start a read")
	`BNFA_ASSERT_NOW(a_res_slot, res_valid, slot_free, "result with output slot busy")
	`BNFA_ASSERT_NOW(a_we_state, mem_we, (state_q == S_CLEAR) || res_valid,
		"map write outside clear or result")
	`BNFA_ASSERT_NOW(a_alloc_limit, res_valid && (res.status == ST_ALLOCATED),
		({1'b0, res.bit_number} < limit), "allocated bit beyond limit")

endmodule

>>> src/bitmap_nearest_free_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_nearest_free_allocator_core
// Next-fit bitmap allocator over a 65536-bit map held in a word RAM.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_ready        req_type, bit_index
//   out      output     out_valid / out_ready      status, bit_number
//   cfg      input      cfg_wr_en                  cfg_wr_data (bits_in_use)
//
// Free: one map word is read, checked and written back. Allocate: map words
// are scanned from the start word (1 to 2048 words), one RAM read per cycle
// through the single read port. After reset the map is cleared one word per
// cycle, all 2048 words, with no input accepted meanwhile. A held output word stalls only the finishing cycle.
// ----------------------------------------------------------------------------
`include "bitmap_nearest_free_allocator_core_macros.svh"

module bitmap_nearest_free_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bnfa_pkg::LIMIT_W-1:0]   cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [bnfa_pkg::BIT_IDX_W-1:0] bit_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [bnfa_pkg::BIT_IDX_W-1:0] bit_number
);
	import bnfa_pkg::*;

	logic [LIMIT_W-1:0]   bits_in_use_q;
	logic [LIMIT_W-1:0]   limit;
	logic                 out_valid_q;
	result_t              out_q;
	logic                 slot_free;
	logic                 res_valid;
	result_t              res;

	assign limit     = (bits_in_use_q < TOTAL_BITS) ? bits_in_use_q : TOTAL_BITS;
	assign slot_free = !out_valid_q || out_ready;

	bnfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.bit_index (bit_index),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= LIMIT_W'(65536);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bits_in_use_q <= cfg_wr_data;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign bit_number = out_q.bit_number;

	`BNFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bit_number),
		"output word dropped while stalled")
	`BNFA_ASSERT_NEXT(a_out_load, res_valid, out_valid, "result not presented")
	`BNFA_ASSERT_NOW(a_limit_cap, 1'b1, limit <= TOTAL_BITS, "limit exceeds map size")

endmodule

>>> test/bitmap_nearest_free_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// bitmap_nearest_free_allocator_core_tb
// Self-checking bench for the bitmap allocator. A shadow copy of
// the allocation map predicts every status word. The bench runs a short
// directed set, then random allocate/free traffic under several valid-bit
// counts, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module bitmap_nearest_free_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bnfa_pkg::*;

	localparam logic [LIMIT_W-1:0] BITS_IN_USE_RESET = LIMIT_W'(65536);
	localparam logic [LIMIT_W-1:0] BITS_IN_USE_MAX   = '1;
	localparam longint             WATCHDOG_CYCLES   = 20_000_000;

	class alloc_tracker;
		word_t                map [MAP_WORDS];
		logic [LIMIT_W-1:0]   bits_in_use;
		result_t              replies [$];
		logic [BIT_IDX_W-1:0] held [$];
		int                   fail_count;

		function new();
			foreach (map[w]) map[w] = '0;
			bits_in_use = BITS_IN_USE_RESET;
			fail_count = 0;
		endfunction

		function int valid_bits();
			return (bits_in_use < TOTAL_BITS) ? int'(bits_in_use) : int'(TOTAL_BITS);
		endfunction

		function result_t resolve(req_t kind, logic [BIT_IDX_W-1:0] idx);
			result_t r;
			word_t   vacant;
			int      lim, origin, w, b, pos;
			lim = valid_bits();
			r.bit_number = idx;
			if (kind == REQ_ALLOC) begin
				r.status = ST_NONE_FREE;
				origin = (int'(idx) < lim) ? int'(idx) : 0;
				for (int n = 0; n < MAP_WORDS; n++) begin
					w = (origin / WORD_BITS + n) % MAP_WORDS;
					vacant = ~map[w];
					if (vacant == '0)
						continue;
					b = 0;
					while (!vacant[b])
						b++;
					pos = w * WORD_BITS + b;
					if (pos >= lim)
						continue;
					map[w][b] = 1'b1;
					r.status = ST_ALLOCATED;
					r.bit_number = BIT_IDX_W'(pos);
					held.push_back(r.bit_number);
					break;
				end
			end else if (int'(idx) >= lim || !map[idx / WORD_BITS][idx % WORD_BITS]) begin
				r.status = ST_FREE_ERROR;
			end else begin
				map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
				r.status = ST_FREED;
			end
			return r;
		endfunction

		function void note_request(req_t kind, logic [BIT_IDX_W-1:0] idx);
			replies.push_back(resolve(kind, idx));
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			fail_count++;
		endtask

		task check_response(status_t st, logic [BIT_IDX_W-1:0] num);
			result_t want;
			if (replies.size() == 0) begin
				report($sformatf("unexpected word: status %0d bit %0d", st, num));
				return;
			end
			want = replies.pop_front();
			if (st !== want.status)
				report($sformatf("status %0d, want %0d", st, want.status));
			if (num !== want.bit_number)
				report($sformatf("bit_number %0d, want %0d", num, want.bit_number));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [LIMIT_W-1:0]   cfg_wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic [BIT_IDX_W-1:0] bit_index;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           status;
	logic [BIT_IDX_W-1:0] bit_number;

	alloc_tracker tracker;
	int           burst_left;
	int           ready_run;
	logic         ready_phase;

	bitmap_nearest_free_allocator_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.bit_index   (bit_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.bit_number  (bit_number)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_CYCLES * 12);
		$display("bitmap_nearest_free_allocator_core verification failed");
		$finish;
	end

	// stall the output on runs of its own
	always @(negedge clk) begin
		if (ready_run == 0) begin
			ready_phase = !ready_phase;
			if (ready_phase)
				ready_run = $urandom_range(1, 40);
			else
				ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) :
					$urandom_range(1, 4);
		end
		ready_run--;
		out_ready <= ready_phase;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_response(status_t'(status), bit_number);
	end

	task automatic send_request(input req_t kind, input logic [BIT_IDX_W-1:0] idx);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		req_type  <= kind;
		bit_index <= idx;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(kind, idx);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_bits_in_use(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.bits_in_use = value;
	endtask

	task automatic send_random(input int alloc_pct);
		int                   lim, pick, lo, hi;
		logic [BIT_IDX_W-1:0] idx;
		lim = tracker.valid_bits();
		lo = (lim > 64) ? lim - 64 : 0;
		hi = (lim + 63 > 65535) ? 65535 : lim + 63;
		pick = $urandom_range(0, 99);
		if (pick < alloc_pct) begin
			case ($urandom_range(0, 2))
				0: idx = BIT_IDX_W'($urandom);
				1: idx = (lim > 0) ? BIT_IDX_W'($urandom_range(0, lim - 1)) : '0;
				default: idx = BIT_IDX_W'($urandom_range(lo, hi));
			endcase
			send_request(REQ_ALLOC, idx);
		end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4 &&
				tracker.held.size() > 0) begin
			pick = $urandom_range(0, tracker.held.size() - 1);
			idx = tracker.held[pick];
			tracker.held.delete(pick);
			send_request(REQ_FREE, idx);
		end else begin
			idx = $urandom_range(0, 1) ? BIT_IDX_W'($urandom) : BIT_IDX_W'($urandom_range(lo, hi));
			send_request(REQ_FREE, idx);
		end
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] setting, input int count,
			input int alloc_pct);
		set_bits_in_use(setting);
		repeat (count) send_random(alloc_pct);
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		req_type    = REQ_ALLOC;
		bit_index   = '0;
		out_ready   = 1'b0;
		burst_left  = 0;
		ready_run   = 0;
		ready_phase = 1'b0;
		tracker     = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// default count: first bits, top word, double free
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_FREE, 16'd65504);
		send_request(REQ_FREE, 16'd65504);
		send_request(REQ_FREE, '1);
		send_request(REQ_ALLOC, 16'd40);
		send_request(REQ_FREE, 16'd1);
		send_request(REQ_ALLOC, '0);
		settle();

		// count beyond the map
		set_bits_in_use(BITS_IN_USE_MAX);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_FREE, '1);
		settle();

		// no valid bit
		set_bits_in_use('0);
		send_request(REQ_ALLOC, '0);
		send_request(REQ_ALLOC, '1);
		send_request(REQ_FREE, '0);
		settle();

		// one valid bit: start out of range, free beyond count
		set_bits_in_use(17'd1);
		send_request(REQ_ALLOC, 16'd5);
		send_request(REQ_FREE, 16'd1);
		send_request(REQ_FREE, '0);
		send_request(REQ_ALLOC, 16'd9);
		settle();

		// top word partly valid
		set_bits_in_use(17'd65520);
		send_request(REQ_ALLOC, 16'd65519);
		send_request(REQ_ALLOC, 16'd65530);
		send_request(REQ_FREE, 16'd65525);
		settle();

		run_phase(BITS_IN_USE_RESET, 450, 60);
		run_phase(BITS_IN_USE_MAX, 250, 55);
		run_phase(LIMIT_W'($urandom_range(65440, 65535)), 250, 60);
		run_phase(LIMIT_W'($urandom_range(2, 160)), 150, 75);
		run_phase(LIMIT_W'($urandom_range(1, 131071)), 300, 55);
		run_phase(LIMIT_W'($urandom_range(1, 64)), 100, 70);
		run_phase(BITS_IN_USE_RESET, 300, 60);

		if (tracker.fail_count == 0)
			$display("bitmap_nearest_free_allocator_core verification clean");
		else
			$display("bitmap_nearest_free_allocator_core verification failed");
		$finish;
	end

endmodule
